### rtl/core/qdx4_pkg.sv
// ----------------------------------------------------------------------------
// qdx4_pkg
// Shared types, constants and the transition table of the x4 quadrature
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qdx4_pkg;

   // Counter width, legal range 16 to 64
   localparam int COUNT_WIDTH = 32;

   // Port payload widths
   localparam int OUT_FIELD_W = 32;
   localparam int AB_W        = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_FIELDS_W = 3 * OUT_FIELD_W + AB_W;
   localparam int RSP_DATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Item kind codes (req_tuser)
   localparam logic KIND_EDGE  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } step_type;

   typedef struct packed {
      logic kind;
      logic pin_a;
      logic pin_b;
      logic edge_a;
      logic edge_b;
   } evt_type;

   typedef struct packed {
      logic [AB_W-1:0] ab;
      count_type       position;
      count_type       invalid;
      count_type       edges;
   } counts_type;

   // Transition table indexed by {previous AB, current AB}
   function automatic step_type step_lookup(logic [AB_W-1:0] prev_ab, logic [AB_W-1:0] cur_ab);
      step_type s;
      case ({prev_ab, cur_ab})
         4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_DOWN;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_UP;
         default:                            s = STEP_NONE;
      endcase
      return s;
   endfunction

   // Sign-extend or truncate the position count to the output field
   function automatic logic [OUT_FIELD_W-1:0] position_out(count_type v);
      logic signed [63:0] w;
      w = 64'(signed'(v));
      return w[OUT_FIELD_W-1:0];
   endfunction

   // Zero-extend or truncate an unsigned count to the output field
   function automatic logic [OUT_FIELD_W-1:0] count_out(count_type v);
      logic [63:0] w;
      w = 64'(v);
      return w[OUT_FIELD_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/core/quadrature_decoder_x4_unit.sv
// Path: an accepted request is held in the input register, then its update is registered in the response register.
// Throughput: 1 transaction per cycle while the response side does not stall; the
//   state update lies between the input register and the response register.
// Reset: synchronous, active high; clears the AB state and all counters and
//   empties both pipeline registers.
// ----------------------------------------------------------------------------
// quadrature_decoder_x4_unit
// Four-counts-per-quadrature-period decoder. Each request carries the sampled
// A/B levels and per-pin edge flags; each response carries the position,
// invalid-transition count, edge count and last AB state after that item.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_x4_unit (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [qdx4_pkg::REQ_DATA_W-1:0]    req_tdata,  // [0] pin_a, [1] pin_b,
                                                          // [2] edge_a, [3] edge_b, pad
   input  wire                                req_tuser,  // [0] kind
   // response channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [qdx4_pkg::RSP_DATA_W-1:0]    rsp_tdata   // [31:0] position,
                                                          // [63:32] invalid_count,
                                                          // [95:64] edge_count,
                                                          // [97:96] ab_state, pad
);

   // Event held in the input register
   qdx4_pkg::evt_type    evt;
   logic                 evt_valid;
   logic                 evt_take;

   // Decoder state
   qdx4_pkg::counts_type state_ff, state_in;
   qdx4_pkg::counts_type state_next;

   // Response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [qdx4_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   qdx4_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .evt_valid  (evt_valid),
      .evt_take   (evt_take),
      .evt        (evt)
   );

   qdx4_step u_step (
      .evt (evt),
      .cur (state_ff),
      .nxt (state_next)
   );

   // Advance the held event when the response register is free or draining
   assign evt_take = evt_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (evt_take) begin
         // commit the update and show it in the same transaction
         state_in     = state_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = qdx4_pkg::RSP_DATA_W'({state_next.ab,
                                               qdx4_pkg::count_out(state_next.edges),
                                               qdx4_pkg::count_out(state_next.invalid),
                                               qdx4_pkg::position_out(state_next.position)});
      end else if (rsp_tready) begin
         // response taken with nothing behind it: drop valid
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/qdx4_in_stage.sv
// ----------------------------------------------------------------------------
// qdx4_in_stage
// Input register: captures one event transaction and holds it until the
// update logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module qdx4_in_stage (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [qdx4_pkg::REQ_DATA_W-1:0]    req_tdata,  // pin_a, pin_b, edge_a, edge_b, pad
   input  wire                                req_tuser,  // kind
   output logic                               evt_valid,
   input  wire                                evt_take,
   output qdx4_pkg::evt_type                  evt
);

   logic              valid_ff, valid_in;
   qdx4_pkg::evt_type evt_ff, evt_in;
   logic              accept;

   assign req_tready = !valid_ff || evt_take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      evt_in   = evt_ff;
      if (accept) begin
         valid_in      = 1'b1;
         evt_in.kind   = req_tuser;
         evt_in.pin_a  = req_tdata[0];
         evt_in.pin_b  = req_tdata[1];
         evt_in.edge_a = req_tdata[2];
         evt_in.edge_b = req_tdata[3];
      end else if (evt_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
   end

   assign evt_valid = valid_ff;
   assign evt       = evt_ff;

endmodule

`default_nettype wire

### rtl/core/qdx4_step.sv
// ----------------------------------------------------------------------------
// qdx4_step
// Next-state logic: clear, table lookup, position step, invalid and edge counts.
// ----------------------------------------------------------------------------
`default_nettype none

module qdx4_step (
   input  qdx4_pkg::evt_type    evt,
   input  qdx4_pkg::counts_type cur,
   output qdx4_pkg::counts_type nxt
);

   logic [qdx4_pkg::AB_W-1:0] cur_ab;
   qdx4_pkg::step_type        step;

   assign cur_ab = {evt.pin_a, evt.pin_b};
   assign step   = qdx4_pkg::step_lookup(cur.ab, cur_ab);

   always_comb begin
      nxt = cur;
      if (evt.kind == qdx4_pkg::KIND_CLEAR) begin
         nxt.ab       = cur_ab;
         nxt.position = '0;
         nxt.invalid  = '0;
         nxt.edges    = '0;
      end else if (evt.edge_a || evt.edge_b) begin
         nxt.ab = cur_ab;
         // both phases moved at once
         if ((cur_ab != cur.ab) && (step == qdx4_pkg::STEP_NONE)) begin
            nxt.invalid = cur.invalid + qdx4_pkg::count_type'(1);
         end
         case (step)
            qdx4_pkg::STEP_UP:   nxt.position = cur.position + qdx4_pkg::count_type'(1);
            qdx4_pkg::STEP_DOWN: nxt.position = cur.position - qdx4_pkg::count_type'(1);
            default:             nxt.position = cur.position;
         endcase
         nxt.edges = cur.edges + qdx4_pkg::count_type'(evt.edge_a)
                               + qdx4_pkg::count_type'(evt.edge_b);
      end
   end

endmodule

`default_nettype wire

### rtl/core/qdx4_checker.sv
// ----------------------------------------------------------------------------
// qdx4_checker
// Port-level assertions for the quadrature decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qdx4_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [qdx4_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // Request side stalls only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled while response path free");

   // Response register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response keeps its valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response valid dropped under stall");

   // A stalled response keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("response payload changed under stall");

endmodule

bind quadrature_decoder_x4_unit qdx4_checker u_qdx4_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
